/* src/amacc_pkg.sv */
package amacc_pkg;

	localparam int NUM_MOMENTS   = 10;
	localparam int MA_W          = $clog2(NUM_MOMENTS);
	localparam int KIND_W        = 4;
	localparam int ACC_WIDTH_DEF = 64;
	localparam int TERM_W        = 34;

	// moment kinds
	localparam logic [MA_W-1:0] MK_ENERGY = MA_W'(0);
	localparam logic [MA_W-1:0] MK_FX     = MA_W'(1);
	localparam logic [MA_W-1:0] MK_FY     = MA_W'(2);
	localparam logic [MA_W-1:0] MK_FZ     = MA_W'(3);
	localparam logic [MA_W-1:0] MK_XX     = MA_W'(4);
	localparam logic [MA_W-1:0] MK_YY     = MA_W'(5);
	localparam logic [MA_W-1:0] MK_ZZ     = MA_W'(6);
	localparam logic [MA_W-1:0] MK_XY     = MA_W'(7);
	localparam logic [MA_W-1:0] MK_XZ     = MA_W'(8);
	localparam logic [MA_W-1:0] MK_YZ     = MA_W'(9);
	localparam logic [MA_W-1:0] MK_LAST   = MA_W'(NUM_MOMENTS - 1);

	// scope codes
	localparam logic SCOPE_GROUP = 1'b0;
	localparam logic SCOPE_CELL  = 1'b1;

	// product rescale selection
	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_Q15  = 2'd1;
	localparam logic [1:0] SH_Q30  = 2'd2;

	// config port
	localparam int   CFG_AW              = 3;
	localparam int   CFG_DW              = 32;
	localparam logic CFG_IDX_MULTI_GROUP = 1'b0;

	typedef struct packed {
		logic [31:0]        intensity;
		logic [15:0]        weight;
		logic signed [15:0] cos_x;
		logic signed [15:0] cos_y;
		logic signed [15:0] cos_z;
		logic               last_angle;
		logic               last_group;
	} in_t;

	typedef struct packed {
		logic [KIND_W-1:0]  moment_kind;
		logic               scope;
		logic signed [63:0] value;
		logic               last_of_run;
	} out_t;

endpackage

/* src/angular_moment_accumulator_top.sv */
// Angular moment accumulator.
// Input channel (in_valid / in_stall / in_data): one beat per angle sample.
// Each beat adds its weighted energy, flux and pressure-tensor terms into ten
// group sums. A beat with last_angle then folds the group sums into the cell
// sums (emitting the group moments first when multi_group is set), and with
// last_group also emits the ten cell totals and clears them.
// Output channel (out_valid / out_stall / out_data): one beat per moment,
// last_of_run set on the final beat caused by an input beat.
// Config: APB write to byte address 0 sets multi_group (bit 0).
// Sequence: an ordinary angle runs a weight multiply, then streams the ten
// moments through the two-stage product pipeline into the group sum RAM,
// then drains before the next accept. A last angle adds a group fold that
// reads, then writes, each moment, and a last group a cell readout that
// does the same; each is limited by the single read port of the sum RAMs.
// Receiver stall: the emitting sweep holds on the moment whose beat cannot
// enter the output register; nothing is dropped. The last result sits in the
// output register while the next angle is already accepted.
// Reset: all sums read as zero (per-entry valid bits), multi_group = 0.
module angular_moment_accumulator_top
	import amacc_pkg::*;
#(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_t              out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0; // waiting for an angle
	localparam logic [2:0] ST_MULW = 3'd1; // w = intensity * weight
	localparam logic [2:0] ST_ACC  = 3'd2; // stream terms into group sums
	localparam logic [2:0] ST_GRD  = 3'd3; // fold: read group and cell entry
	localparam logic [2:0] ST_GWR  = 3'd4; // fold: emit group if multi_group, clear group, update cell
	localparam logic [2:0] ST_CRD  = 3'd5; // readout: read cell entry
	localparam logic [2:0] ST_CWR  = 3'd6; // readout: emit and clear cell

	logic [2:0] state_q;
	in_t        in_q;
	logic       multi_group_q;

	logic [31:0]     w_q;
	logic [MA_W-1:0] k_q;
	logic            acc_done_q;

	// product pipeline
	logic                   v_s1, v_s2;
	logic [MA_W-1:0]        k_s1, k_s2;
	logic [1:0]             sh_s1, sh_s2;
	logic signed [31:0]     coef_s1;
	logic signed [64:0]     prod_s2;

	// sum RAMs and their reset-valid bits
	logic [NUM_MOMENTS-1:0] gvalid_q, cvalid_q;
	logic                   grv_q, crv_q;
	logic                   g_we, g_re, c_we, c_re;
	logic [MA_W-1:0]        g_waddr, g_raddr;
	logic [ACC_WIDTH-1:0]   g_wdata, c_wdata, g_rdata, c_rdata;
	logic signed [ACC_WIDTH-1:0] g_val, c_val, g_new, c_new, term_ext;

	// output register
	logic out_valid_q;
	out_t out_q;
	logic out_free;
	logic emit;
	out_t emit_data;

	logic       accept;
	logic       iss;
	logic       step;
	logic [2:0] state_d;
	logic       cfg_we;

	logic signed [15:0]  opa, opb;
	logic [1:0]          mode_c;
	logic signed [31:0]  coef_c;
	logic signed [64:0]  shifted;
	logic signed [TERM_W-1:0] term_c;
	logic [47:0]         iw;

	function automatic logic signed [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] a,
		input logic signed [ACC_WIDTH-1:0] b
	);
		logic signed [ACC_WIDTH:0] s;
		logic signed [ACC_WIDTH-1:0] r;
		s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
			r = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
			                 : {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end else begin
			r = s[ACC_WIDTH-1:0];
		end
		return r;
	endfunction

	// ---------------- config port ----------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready
	                && (paddr[CFG_AW-1] == CFG_IDX_MULTI_GROUP);
	assign prdata = (paddr[CFG_AW-1] == CFG_IDX_MULTI_GROUP)
	                ? {{(CFG_DW-1){1'b0}}, multi_group_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multi_group_q <= 1'b0;
		end else if (cfg_we) begin
			multi_group_q <= pwdata[0];
		end
	end

	// ---------------- handshakes ----------------
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
	end

	// ---------------- weighted intensity ----------------
	assign iw = 48'(in_q.intensity) * 48'(in_q.weight);

	always_ff @(posedge clk) begin
		if (state_q == ST_MULW) begin
			w_q <= iw[47:16];
		end
	end

	// ---------------- stage 0: coefficient per moment ----------------
	assign iss = (state_q == ST_ACC) && !acc_done_q;

	always_comb begin
		opa    = in_q.cos_x;
		opb    = in_q.cos_x;
		mode_c = SH_Q30;
		case (k_q)
			MK_ENERGY: mode_c = SH_NONE;
			MK_FX: begin opa = in_q.cos_x; mode_c = SH_Q15; end
			MK_FY: begin opa = in_q.cos_y; mode_c = SH_Q15; end
			MK_FZ: begin opa = in_q.cos_z; mode_c = SH_Q15; end
			MK_XX: begin opa = in_q.cos_x; opb = in_q.cos_x; end
			MK_YY: begin opa = in_q.cos_y; opb = in_q.cos_y; end
			MK_ZZ: begin opa = in_q.cos_z; opb = in_q.cos_z; end
			MK_XY: begin opa = in_q.cos_x; opb = in_q.cos_y; end
			MK_XZ: begin opa = in_q.cos_x; opb = in_q.cos_z; end
			MK_YZ: begin opa = in_q.cos_y; opb = in_q.cos_z; end
			default: mode_c = SH_NONE;
		endcase
	end

	always_comb begin
		case (mode_c)
			SH_NONE: coef_c = 32'sd1;
			SH_Q15:  coef_c = 32'(opa);
			SH_Q30:  coef_c = opa * opb;
			default: coef_c = '0;
		endcase
	end

	// ---------------- stage 1 / 2 registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= iss;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (iss) begin
			k_s1    <= k_q;
			sh_s1   <= mode_c;
			coef_s1 <= coef_c;
		end
		k_s2    <= k_s1;
		sh_s2   <= sh_s1;
		prod_s2 <= $signed({1'b0, w_q}) * coef_s1;
	end

	// stage 2: rescale (arithmetic shift floors) and accumulate
	always_comb begin
		case (sh_s2)
			SH_NONE: shifted = prod_s2;
			SH_Q15:  shifted = prod_s2 >>> 15;
			SH_Q30:  shifted = prod_s2 >>> 30;
			default: shifted = prod_s2;
		endcase
	end

	assign term_c   = shifted[TERM_W-1:0];
	assign term_ext = ACC_WIDTH'(term_c);

	// never-written entries read as zero
	assign g_val = grv_q ? g_rdata : '0;
	assign c_val = crv_q ? c_rdata : '0;
	assign g_new = sat_add(g_val, term_ext);
	assign c_new = sat_add(c_val, g_val);

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		step    = 1'b0;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_MULW;
			ST_MULW: state_d = ST_ACC;
			ST_ACC: begin
				if (acc_done_q && !v_s1) begin
					state_d = in_q.last_angle ? ST_GRD : ST_IDLE;
				end
			end
			ST_GRD: state_d = ST_GWR;
			ST_GWR: begin
				step = !multi_group_q || out_free;
				if (step) begin
					if (k_q == MK_LAST) begin
						state_d = in_q.last_group ? ST_CRD : ST_IDLE;
					end else begin
						state_d = ST_GRD;
					end
				end
			end
			ST_CRD: state_d = ST_CWR;
			ST_CWR: begin
				step = out_free;
				if (step) begin
					state_d = (k_q == MK_LAST) ? ST_IDLE : ST_CRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			acc_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_MULW: begin
					k_q        <= '0;
					acc_done_q <= 1'b0;
				end
				ST_ACC: begin
					if (iss) begin
						if (k_q == MK_LAST) begin
							acc_done_q <= 1'b1;
							k_q        <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_GWR, ST_CWR: begin
					if (step) begin
						k_q <= (k_q == MK_LAST) ? '0 : k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- RAM ports ----------------
	assign g_re    = (state_q == ST_ACC && v_s1) || (state_q == ST_GRD);
	assign g_raddr = (state_q == ST_ACC) ? k_s1 : k_q;
	assign g_we    = (state_q == ST_ACC && v_s2) || (state_q == ST_GWR && step);
	assign g_waddr = (state_q == ST_ACC) ? k_s2 : k_q;
	assign g_wdata = (state_q == ST_ACC) ? g_new : '0;

	assign c_re    = (state_q == ST_GRD) || (state_q == ST_CRD);
	assign c_we    = (state_q == ST_GWR || state_q == ST_CWR) && step;
	assign c_wdata = (state_q == ST_GWR) ? c_new : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gvalid_q <= '0;
			cvalid_q <= '0;
			grv_q    <= 1'b0;
			crv_q    <= 1'b0;
		end else begin
			if (g_we) gvalid_q[g_waddr] <= 1'b1;
			if (c_we) cvalid_q[k_q] <= 1'b1;
			if (g_re) grv_q <= gvalid_q[g_raddr];
			if (c_re) crv_q <= cvalid_q[k_q];
		end
	end

	amacc_ram #(
		.WIDTH (ACC_WIDTH),
		.DEPTH (NUM_MOMENTS)
	) u_group_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (g_re),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	amacc_ram #(
		.WIDTH (ACC_WIDTH),
		.DEPTH (NUM_MOMENTS)
	) u_cell_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (k_q),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (k_q),
		.rdata (c_rdata)
	);

	// ---------------- result beats ----------------
	always_comb begin
		emit_data.moment_kind = KIND_W'(k_q);
		emit_data.scope       = SCOPE_GROUP;
		emit_data.value       = 64'(g_val);
		emit_data.last_of_run = (k_q == MK_LAST) && !in_q.last_group;
		emit                  = 1'b0;
		case (state_q)
			ST_GWR: emit = step && multi_group_q;
			ST_CWR: begin
				emit                  = step;
				emit_data.scope       = SCOPE_CELL;
				emit_data.value       = 64'(c_val);
				emit_data.last_of_run = (k_q == MK_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_data;
		end
	end

endmodule

/* src/amacc_ram.sv */
module amacc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* dv/angular_moment_accumulator_top_test.sv */
`timescale 1ns / 1ps

module angular_moment_accumulator_top_test;
	import amacc_pkg::*;

	// run shape
	localparam int          LIMIT_CYCLES  = 800000;
	localparam int          SETTLE_CYCLES = 64;   // covers an angle plus the sweeps
	localparam int          PHASE_ITEMS   = 60;
	localparam int          NUM_PHASES    = 4;

	// register map: one register, byte address 4*index
	localparam logic [CFG_AW-1:0] ADDR_MULTI_GROUP = CFG_AW'(4 * CFG_IDX_MULTI_GROUP);
	localparam logic [CFG_AW-1:0] ADDR_UNMAPPED    = ADDR_MULTI_GROUP + CFG_AW'(4);

	// accumulator range, signed ACC_WIDTH_DEF bits
	localparam logic signed [65:0] SUM_MAX = (66'sd1 <<< (ACC_WIDTH_DEF - 1)) - 66'sd1;
	localparam logic signed [65:0] SUM_MIN = -SUM_MAX - 66'sd1;

	// one row of the directed table: either a register write or an angle beat,
	// optionally with the energy value written down by hand
	typedef struct {
		bit                is_cfg;
		logic [CFG_AW-1:0] addr;
		logic [CFG_DW-1:0] data;
		in_t               beat;
		bit                pin_on;
		longint            pin_energy;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_t               in_data;
	logic              out_valid;
	logic              out_stall;
	out_t              out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	// predictor state
	longint            group_acc [NUM_MOMENTS];
	longint            cell_acc  [NUM_MOMENTS];
	bit                multi_group_mode;
	out_t              moments_due [$];

	dir_row_t          dir_tab [$];
	bit                quiet;
	int                n_errors;
	int                n_beats;
	int                n_checked;
	int                n_settings;
	int                n_cycles;

	angular_moment_accumulator_top #(
		.ACC_WIDTH(ACC_WIDTH_DEF)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// saturating add into a signed ACC_WIDTH-bit sum
	function automatic longint sat_sum(input longint a, input longint b);
		logic signed [65:0] s;
		s = a;
		s = s + b;
		if (s > SUM_MAX)
			s = SUM_MAX;
		else if (s < SUM_MIN)
			s = SUM_MIN;
		return longint'(s[63:0]);
	endfunction

	function automatic dir_row_t row_beat(input logic [31:0] inten, input logic [15:0] wt,
		input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] cz,
		input bit la, input bit lg, input bit pin_on, input longint pin_e);
		dir_row_t r;
		r.is_cfg            = 1'b0;
		r.addr              = '0;
		r.data              = '0;
		r.beat.intensity    = inten;
		r.beat.weight       = wt;
		r.beat.cos_x        = cx;
		r.beat.cos_y        = cy;
		r.beat.cos_z        = cz;
		r.beat.last_angle   = la;
		r.beat.last_group   = lg;
		r.pin_on            = pin_on;
		r.pin_energy        = pin_e;
		return r;
	endfunction

	function automatic dir_row_t row_cfg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
		dir_row_t r;
		r            = row_beat('0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 0);
		r.is_cfg     = 1'b1;
		r.addr       = a;
		r.data       = d;
		return r;
	endfunction

	// Random angle content: mostly full-range, sometimes the edges of each field.
	function automatic in_t rand_angle(input bit la, input bit lg);
		in_t b;
		case ($urandom_range(0, 5))
			0: b.intensity = 32'hFFFF_FFFF;
			1: b.intensity = $urandom_range(0, 32'h0003_FFFF);
			default: b.intensity = $urandom;
		endcase
		case ($urandom_range(0, 7))
			0: b.weight = 16'hFFFF;
			1: b.weight = 16'h0000;
			default: b.weight = 16'($urandom);
		endcase
		b.cos_x = ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom);
		b.cos_y = ($urandom_range(0, 7) == 0) ? 16'h7FFF : 16'($urandom);
		b.cos_z = ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom);
		b.last_angle = la;
		b.last_group = lg;
		return b;
	endfunction

	// Adds one angle into the group sums and queues the moments it releases.
	task automatic predict_moments(input in_t b, input bit pin_on, input longint pin_e);
		logic [47:0] iw;
		longint      w;
		longint      cx;
		longint      cy;
		longint      cz;
		longint      term [NUM_MOMENTS];
		out_t        r;
		out_t        batch [$];
		iw = {16'd0, b.intensity} * {32'd0, b.weight};
		w  = {32'd0, iw[47:16]};
		cx = {{48{b.cos_x[15]}}, b.cos_x};
		cy = {{48{b.cos_y[15]}}, b.cos_y};
		cz = {{48{b.cos_z[15]}}, b.cos_z};
		// >>> on a signed longint floors toward minus infinity
		term[MK_ENERGY] = w;
		term[MK_FX]     = (w * cx) >>> 15;
		term[MK_FY]     = (w * cy) >>> 15;
		term[MK_FZ]     = (w * cz) >>> 15;
		term[MK_XX]     = (w * (cx * cx)) >>> 30;
		term[MK_YY]     = (w * (cy * cy)) >>> 30;
		term[MK_ZZ]     = (w * (cz * cz)) >>> 30;
		term[MK_XY]     = (w * (cx * cy)) >>> 30;
		term[MK_XZ]     = (w * (cx * cz)) >>> 30;
		term[MK_YZ]     = (w * (cy * cz)) >>> 30;
		for (int k = MK_ENERGY; k <= MK_LAST; k++)
			group_acc[k] = sat_sum(group_acc[k], term[k]);
		// last_group alone is ignored; nothing comes out without last_angle
		if (!b.last_angle)
			return;
		if (multi_group_mode) begin
			for (int k = MK_ENERGY; k <= MK_LAST; k++) begin
				r.moment_kind = KIND_W'(k);
				r.scope       = SCOPE_GROUP;
				r.value       = (pin_on && k == MK_ENERGY) ? pin_e : group_acc[k];
				r.last_of_run = 1'b0;
				batch.push_back(r);
			end
		end
		// single-group mode still folds the group into the cell
		for (int k = MK_ENERGY; k <= MK_LAST; k++) begin
			cell_acc[k]  = sat_sum(cell_acc[k], group_acc[k]);
			group_acc[k] = 0;
		end
		if (b.last_group) begin
			for (int k = MK_ENERGY; k <= MK_LAST; k++) begin
				r.moment_kind = KIND_W'(k);
				r.scope       = SCOPE_CELL;
				r.value       = (pin_on && k == MK_ENERGY) ? pin_e : cell_acc[k];
				r.last_of_run = 1'b0;
				batch.push_back(r);
				cell_acc[k] = 0;
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last_of_run = 1'b1;
		foreach (batch[i])
			moments_due.push_back(batch[i]);
	endtask

	// Drives one angle beat until accepted, then maybe opens an input gap.
	task automatic send_angle(input in_t b, input bit pin_on, input longint pin_e);
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		predict_moments(b, pin_on, pin_e);
		n_beats++;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Waits until every queued moment came out and the pipeline went quiet.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (moments_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: setup phase, access phase, then psel dropped low.
	task automatic apb_xfer(input bit wr, input logic [CFG_AW-1:0] a,
		input logic [CFG_DW-1:0] d, output logic [CFG_DW-1:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_mode_readback();
		logic [CFG_DW-1:0] rd;
		apb_xfer(1'b0, ADDR_MULTI_GROUP, '0, rd);
		if (rd[0] !== multi_group_mode) begin
			$display("%0t multi_group readback: expected %0d, actual %0d",
				$time, multi_group_mode, rd[0]);
			n_errors++;
		end
	endtask

	// Register write on an idle block; unmapped addresses change nothing.
	task automatic set_register(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
		logic [CFG_DW-1:0] rd;
		wait_idle();
		apb_xfer(1'b1, a, d, rd);
		if (a == ADDR_MULTI_GROUP)
			multi_group_mode = d[0];
		n_settings++;
		check_mode_readback();
	endtask

	task automatic report_field(input string name, input longint want, input longint got);
		$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		n_errors++;
	endtask

	// output side: compare each accepted beat with the oldest queued moment
	always @(posedge clk) begin : mon_moments
		out_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (moments_due.size() == 0) begin
				$display("%0t unexpected moment beat: expected none, actual kind %0d value %0d",
					$time, out_data.moment_kind, out_data.value);
				n_errors++;
			end else begin
				want = moments_due.pop_front();
				n_checked++;
				if (out_data.moment_kind !== want.moment_kind)
					report_field("moment_kind", want.moment_kind, out_data.moment_kind);
				if (out_data.scope !== want.scope)
					report_field("scope", want.scope, out_data.scope);
				if (out_data.value !== want.value)
					report_field("value", want.value, out_data.value);
				if (out_data.last_of_run !== want.last_of_run)
					report_field("last_of_run", want.last_of_run, out_data.last_of_run);
			end
		end
	end

	// receiver back-pressure: random bursts, calm stretches, none once quiet
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!quiet) begin
				if ($urandom_range(0, 5) == 0) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 13)) @(posedge clk);
					out_stall <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					repeat ($urandom_range(30, 120)) @(posedge clk);
				end
			end
		end
	end

	// watchdog
	initial begin
		n_cycles = 0;
		while (n_cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			n_cycles++;
		end
		$display("angular_moment_accumulator_top regression: fail");
		$finish;
	end

	initial begin
		int  p;
		int  sent;
		int  n_groups;
		int  n_angles;
		bit  la;
		bit  lg;
		bit  mode;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		quiet      = 1'b0;
		n_errors   = 0;
		n_beats    = 0;
		n_checked  = 0;
		n_settings = 0;
		multi_group_mode = 1'b0;
		for (int k = 0; k < NUM_MOMENTS; k++) begin
			group_acc[k] = 0;
			cell_acc[k]  = 0;
		end

		// Directed table. Pinned energies: each pinned row closes a single-angle
		// cell on a cleared cell, so its energy is just the weighted intensity.
		// reset mode: cell totals only
		dir_tab.push_back(row_beat(32'h0000_0000, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1, 1, 1, 0));
		dir_tab.push_back(row_beat(32'hFFFF_FFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
			1, 1, 1, 0));
		dir_tab.push_back(row_beat(32'h0001_0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000,
			1, 1, 1, 65535));
		dir_tab.push_back(row_beat(32'hFFFF_FFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000,
			1, 1, 1, 64'd4294901759));
		// group mark without angle mark: ignored, just accumulates
		dir_tab.push_back(row_beat(32'h1234_5678, 16'h8000, 16'h4000, 16'hC000, 16'h2000,
			0, 1, 0, 0));
		// no mark
		dir_tab.push_back(row_beat(32'h0000_FFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000,
			0, 0, 0, 0));
		// group close, per-group moments suppressed in single-group mode
		dir_tab.push_back(row_beat(32'hFFFF_0000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000,
			1, 0, 0, 0));
		dir_tab.push_back(row_beat(32'h8000_0000, 16'h0001, 16'h8001, 16'h7FFF, 16'hFFFF,
			1, 1, 0, 0));
		// multi-group mode
		dir_tab.push_back(row_cfg(ADDR_MULTI_GROUP, 32'h0000_0001));
		dir_tab.push_back(row_beat(32'h0001_0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
			1, 1, 1, 32768));
		dir_tab.push_back(row_beat(32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF,
			0, 0, 0, 0));
		dir_tab.push_back(row_beat(32'hABCD_1234, 16'h1234, 16'h5A5A, 16'hA5A5, 16'h0F0F,
			1, 0, 0, 0));
		dir_tab.push_back(row_beat(32'h0003_0000, 16'hC000, 16'h1000, 16'hE000, 16'h7FFF,
			1, 1, 0, 0));
		// write past the register list: must leave multi_group alone
		dir_tab.push_back(row_cfg(ADDR_UNMAPPED, 32'h0000_0000));
		dir_tab.push_back(row_beat(32'h7FFF_FFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000,
			1, 1, 0, 0));
		// only bit 0 counts
		dir_tab.push_back(row_cfg(ADDR_MULTI_GROUP, 32'hFFFF_FFFE));
		dir_tab.push_back(row_beat(32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000,
			1, 1, 1, 64'd4294901759));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// multi_group comes out of reset as zero
		check_mode_readback();

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				set_register(dir_tab[i].addr, dir_tab[i].data);
			else
				send_angle(dir_tab[i].beat, dir_tab[i].pin_on, dir_tab[i].pin_energy);
		end

		// Random part: mostly well-formed cells (1-3 groups of 1-5 angles),
		// with a few broken marks mixed in. Last phase runs without idling.
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: mode = 1'b1;
				1: mode = 1'b0;
				2: mode = $urandom_range(0, 1);
				default: mode = 1'b1;
			endcase
			set_register(ADDR_MULTI_GROUP, ($urandom & ~32'h1) | {31'd0, mode});
			quiet = (p == NUM_PHASES - 1);
			sent  = 0;
			while (sent < PHASE_ITEMS) begin
				n_groups = $urandom_range(1, 3);
				for (int g = 0; g < n_groups; g++) begin
					n_angles = $urandom_range(1, 5);
					for (int a = 0; a < n_angles; a++) begin
						la = (a == n_angles - 1);
						lg = la && (g == n_groups - 1);
						if ($urandom_range(0, 9) == 0) begin
							la = $urandom_range(0, 1);
							lg = $urandom_range(0, 1);
						end
						send_angle(rand_angle(la, lg), 1'b0, 0);
						sent++;
					end
				end
			end
		end

		wait_idle();

		$display("sent %0d angle beats over %0d register writes, checked %0d moment beats",
			n_beats, n_settings, n_checked);
		if (n_errors == 0)
			$display("angular_moment_accumulator_top regression: pass");
		else
			$display("angular_moment_accumulator_top regression: fail");
		$finish;
	end

endmodule

/* files.f */
src/amacc_pkg.sv
src/amacc_ram.sv
src/angular_moment_accumulator_top.sv
dv/angular_moment_accumulator_top_test.sv
